@@ rtl/lmcc_pkg.sv @@
package lmcc_pkg;

  // chain size limits
  localparam int MAX_DEVICES_DEF = 8;
  localparam logic [3:0] COUNT_RESET = 4'd4;

  // driver opcodes and masks
  localparam logic [7:0] OPC_INTENSITY = 8'd10;
  localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
  localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;
  localparam logic [7:0] LED_MASK      = 8'b1000_0000;
  localparam logic [7:0] SCAN_MAX      = 8'd7;
  localparam logic [7:0] INTENS_MAX    = 8'd15;
  localparam logic [2:0] ROW_LAST      = 3'd7;

  // configuration register addresses
  localparam logic [1:0] ADDR_DEVICE_COUNT = 2'd0;

  // host commands
  typedef enum logic [2:0] {
    CMD_RAW      = 3'd0,
    CMD_SET_LED  = 3'd1,
    CMD_CLEAR    = 3'd2,
    CMD_SCAN     = 3'd3,
    CMD_INTENS   = 3'd4,
    CMD_SHUTDOWN = 3'd5
  } cmd_e;

  // datapath actions of one control word
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_PREP     = 3'd1,
    ACT_EMIT     = 3'd2,
    ACT_MODIFY   = 3'd3,
    ACT_CLR_ROW  = 3'd4,
    ACT_NEXT_ROW = 3'd5
  } act_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS       = 3'd0,
    COND_NO_START     = 3'd1,
    COND_BAD          = 3'd2,
    COND_SET_LED      = 3'd3,
    COND_CLEAR        = 3'd4,
    COND_POS_NZ       = 3'd5,
    COND_ROW_NOT_LAST = 3'd6
  } cond_e;

  localparam int PC_W = 4;

  // program step labels
  localparam logic [PC_W-1:0] S_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] S_CHECK    = 4'd1;
  localparam logic [PC_W-1:0] S_IS_LED   = 4'd2;
  localparam logic [PC_W-1:0] S_IS_CLR   = 4'd3;
  localparam logic [PC_W-1:0] S_EMIT     = 4'd4;
  localparam logic [PC_W-1:0] S_DONE     = 4'd5;
  localparam logic [PC_W-1:0] S_MODIFY   = 4'd6;
  localparam logic [PC_W-1:0] S_CLR_ROW  = 4'd7;
  localparam logic [PC_W-1:0] S_CLR_EMIT = 4'd8;
  localparam logic [PC_W-1:0] S_CLR_NEXT = 4'd9;
  localparam logic [PC_W-1:0] S_CLR_DONE = 4'd10;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    act_e act;
    logic busy;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic start;
    logic bad;
    logic set_led;
    logic clear;
    logic pos_nz;
    logic row_not_last;
  } flags_t;

  // microprogram: jump to target when the condition holds, else next step
  function automatic ucode_t rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: S_WAIT};
    case (pc)
      S_WAIT:     w = '{act: ACT_NONE,     cond: COND_NO_START,     target: S_WAIT};
      S_CHECK:    w = '{act: ACT_PREP,     cond: COND_BAD,          target: S_WAIT};
      S_IS_LED:   w = '{act: ACT_NONE,     cond: COND_SET_LED,      target: S_MODIFY};
      S_IS_CLR:   w = '{act: ACT_NONE,     cond: COND_CLEAR,        target: S_CLR_ROW};
      S_EMIT:     w = '{act: ACT_EMIT,     cond: COND_POS_NZ,       target: S_EMIT};
      S_DONE:     w = '{act: ACT_NONE,     cond: COND_ALWAYS,       target: S_WAIT};
      S_MODIFY:   w = '{act: ACT_MODIFY,   cond: COND_ALWAYS,       target: S_EMIT};
      S_CLR_ROW:  w = '{act: ACT_CLR_ROW,  cond: COND_ALWAYS,       target: S_CLR_EMIT};
      S_CLR_EMIT: w = '{act: ACT_EMIT,     cond: COND_POS_NZ,       target: S_CLR_EMIT};
      S_CLR_NEXT: w = '{act: ACT_NEXT_ROW, cond: COND_ROW_NOT_LAST, target: S_CLR_ROW};
      S_CLR_DONE: w = '{act: ACT_NONE,     cond: COND_ALWAYS,       target: S_WAIT};
      default:    w = '{act: ACT_NONE,     cond: COND_ALWAYS,       target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/lmcc_seq.sv @@
module lmcc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmcc_pkg::flags_t  flags_i,
  output lmcc_pkg::ctl_t    ctl_o
);

  logic [lmcc_pkg::PC_W-1:0] pc_q, pc_d;
  lmcc_pkg::ucode_t          uw;
  logic                      taken;

  // fetch the control word of the current step
  assign uw = lmcc_pkg::rom(pc_q);

  // evaluate the jump condition
  always_comb begin
    case (uw.cond)
      lmcc_pkg::COND_ALWAYS:       taken = 1'b1;
      lmcc_pkg::COND_NO_START:     taken = !flags_i.start;
      lmcc_pkg::COND_BAD:          taken = flags_i.bad;
      lmcc_pkg::COND_SET_LED:      taken = flags_i.set_led;
      lmcc_pkg::COND_CLEAR:        taken = flags_i.clear;
      lmcc_pkg::COND_POS_NZ:       taken = flags_i.pos_nz;
      lmcc_pkg::COND_ROW_NOT_LAST: taken = flags_i.row_not_last;
      default:                     taken = 1'b1;
    endcase
  end

  // step counter
  assign pc_d = taken ? uw.target : pc_q + lmcc_pkg::PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= lmcc_pkg::S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o.act  = uw.act;
  assign ctl_o.busy = (pc_q != lmcc_pkg::S_WAIT);

endmodule

@@ rtl/lmcc_dp.sv @@
module lmcc_dp #(
  parameter int MAX_DEVICES = lmcc_pkg::MAX_DEVICES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmcc_pkg::ctl_t    ctl_i,
  output lmcc_pkg::flags_t  flags_o,
  input  logic [3:0]        device_count_i,
  input  logic              start_i,
  input  logic [2:0]        command_i,
  input  logic [2:0]        device_i,
  input  logic [3:0]        register_address_i,
  input  logic [7:0]        value_i,
  input  logic [2:0]        row_i,
  input  logic [2:0]        column_i,
  input  logic              flag_i,
  output logic              word_valid_o,
  output logic [15:0]       word_o,
  output logic [2:0]        word_device_o,
  output logic              frame_end_o,
  output logic              last_o
);

  localparam int DEPTH = MAX_DEVICES * 8;
  localparam int AW    = $clog2(MAX_DEVICES) + 3;
  localparam logic [3:0] MAX_N = 4'(MAX_DEVICES);

  // latched transaction
  logic [2:0] cmd_q, dev_q, row_q, col_q;
  logic [3:0] reg_q;
  logic [7:0] val_q;
  logic       flag_q;

  // frame state
  logic [2:0] pos_q, rowi_q;
  logic [7:0] opc_q, data_q;

  // row shadow memory with per-entry valid bits
  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_q;
  logic             rd_valid_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata;

  // result registers
  logic        out_valid_q;
  logic [15:0] out_word_q;
  logic [2:0]  out_dev_q;
  logic        out_fe_q, out_last_q;

  logic [3:0] n_eff;
  logic       accept;
  logic [7:0] cur_row, led_mask, new_row;

  assign accept = start_i && !ctl_i.busy;

  // chain length saturated to the supported maximum
  assign n_eff = (device_count_i > MAX_N) ? MAX_N : device_count_i;

  // capture the command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      dev_q  <= device_i;
      reg_q  <= register_address_i;
      val_q  <= value_i;
      row_q  <= row_i;
      col_q  <= column_i;
      flag_q <= flag_i;
    end
  end

  // condition flags for the sequencer
  always_comb begin
    flags_o.start        = start_i;
    flags_o.bad          = ({1'b0, dev_q} >= n_eff)
                        || (cmd_q > lmcc_pkg::CMD_SHUTDOWN)
                        || ((cmd_q == lmcc_pkg::CMD_SCAN) && (val_q > lmcc_pkg::SCAN_MAX))
                        || ((cmd_q == lmcc_pkg::CMD_INTENS) && (val_q > lmcc_pkg::INTENS_MAX));
    flags_o.set_led      = (cmd_q == lmcc_pkg::CMD_SET_LED);
    flags_o.clear        = (cmd_q == lmcc_pkg::CMD_CLEAR);
    flags_o.pos_nz       = (pos_q != 3'd0);
    flags_o.row_not_last = (rowi_q != lmcc_pkg::ROW_LAST);
  end

  // read-modify-write of one led bit
  assign cur_row  = rd_valid_q ? rd_q : 8'd0;
  assign led_mask = lmcc_pkg::LED_MASK >> col_q;
  assign new_row  = flag_q ? (cur_row | led_mask) : (cur_row & ~led_mask);

  // shadow write port
  always_comb begin
    we    = 1'b0;
    waddr = AW'({dev_q, row_q});
    wdata = new_row;
    case (ctl_i.act)
      lmcc_pkg::ACT_MODIFY: begin
        we = 1'b1;
      end
      lmcc_pkg::ACT_CLR_ROW: begin
        we    = 1'b1;
        waddr = AW'({dev_q, rowi_q});
        wdata = 8'd0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = AW'({dev_q, row_q});

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q       <= mem_q[raddr];
    rd_valid_q <= valid_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // frame setup and position counter
  always_ff @(posedge clk_i) begin
    case (ctl_i.act)
      lmcc_pkg::ACT_PREP: begin
        pos_q  <= 3'(n_eff - 4'd1);
        rowi_q <= 3'd0;
        data_q <= val_q;
        case (cmd_q)
          lmcc_pkg::CMD_RAW:    opc_q <= {4'd0, reg_q};
          lmcc_pkg::CMD_SCAN:   opc_q <= lmcc_pkg::OPC_SCANLIMIT;
          lmcc_pkg::CMD_INTENS: opc_q <= lmcc_pkg::OPC_INTENSITY;
          lmcc_pkg::CMD_SHUTDOWN: begin
            opc_q  <= lmcc_pkg::OPC_SHUTDOWN;
            data_q <= {7'd0, !flag_q};
          end
          default:              opc_q <= {5'd0, row_q} + 8'd1;
        endcase
      end
      lmcc_pkg::ACT_MODIFY: begin
        data_q <= new_row;
      end
      lmcc_pkg::ACT_CLR_ROW: begin
        pos_q  <= 3'(n_eff - 4'd1);
        opc_q  <= {5'd0, rowi_q} + 8'd1;
        data_q <= 8'd0;
      end
      lmcc_pkg::ACT_EMIT: begin
        pos_q <= pos_q - 3'd1;
      end
      lmcc_pkg::ACT_NEXT_ROW: begin
        rowi_q <= rowi_q + 3'd1;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (ctl_i.act == lmcc_pkg::ACT_EMIT);
    end
  end

  // result payload, farthest chip first
  always_ff @(posedge clk_i) begin
    if (ctl_i.act == lmcc_pkg::ACT_EMIT) begin
      out_word_q <= (pos_q == dev_q) ? {opc_q, data_q} : 16'd0;
      out_dev_q  <= pos_q;
      out_fe_q   <= (pos_q == 3'd0);
      out_last_q <= (pos_q == 3'd0)
                 && ((cmd_q != lmcc_pkg::CMD_CLEAR) || (rowi_q == lmcc_pkg::ROW_LAST));
    end
  end

  assign word_valid_o  = out_valid_q;
  assign word_o        = out_word_q;
  assign word_device_o = out_dev_q;
  assign frame_end_o   = out_fe_q;
  assign last_o        = out_last_q;

endmodule

@@ rtl/led_matrix_chain_controller_unit.sv @@
// a started command is checked and decoded, then its frame is emitted; words are registered and
//   strobed one per cycle within a frame, and clear display runs a row-clear step before each frame
// a frame holds n = chain length words; clear display sends eight frames, a rejected command none
// start is ignored while busy; rate is set by the microcode step counter, one control word per cycle
// reset: chain length returns to 4, row shadow reads as all zeros, sequencer idles
// results are strobed for one cycle; the receiver cannot stall
module led_matrix_chain_controller_unit #(
  parameter int MAX_DEVICES = lmcc_pkg::MAX_DEVICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [2:0]  device_i,
  input  logic [3:0]  register_address_i,
  input  logic [7:0]  value_i,
  input  logic [2:0]  row_i,
  input  logic [2:0]  column_i,
  input  logic        flag_i,
  // result channel
  output logic        word_valid_o,
  output logic [15:0] word_o,
  output logic [2:0]  word_device_o,
  output logic        frame_end_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lmcc_pkg::ctl_t   ctl;
  lmcc_pkg::flags_t flags;
  logic [3:0]       device_count_q;
  logic             cfg_wr;

  // configuration register write
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr == lmcc_pkg::ADDR_DEVICE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_count_q <= lmcc_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      device_count_q <= pwdata[3:0];
    end
  end

  // configuration read back
  assign prdata = (paddr == lmcc_pkg::ADDR_DEVICE_COUNT) ? {28'd0, device_count_q} : 32'd0;
  assign pready = 1'b1;

  assign busy = ctl.busy;

  // microcode sequencer
  lmcc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  // shadow memory and frame datapath
  lmcc_dp #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .flags_o            (flags),
    .device_count_i     (device_count_q),
    .start_i            (start),
    .command_i          (command_i),
    .device_i           (device_i),
    .register_address_i (register_address_i),
    .value_i            (value_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .flag_i             (flag_i),
    .word_valid_o       (word_valid_o),
    .word_o             (word_o),
    .word_device_o      (word_device_o),
    .frame_end_o        (frame_end_o),
    .last_o             (last_o)
  );

endmodule

@@ verif/led_matrix_chain_controller_unit_tb.sv @@
`timescale 1ns / 100ps

module led_matrix_chain_controller_unit_tb;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BLOCK_ITEMS    = 15;

  // command codes the block does not know
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] device;
    logic [3:0] reg_addr;
    logic [7:0] value;
    logic [2:0] row;
    logic [2:0] column;
    logic       flag;
  } host_cmd_t;

  typedef struct packed {
    logic [15:0] word;
    logic [2:0]  device;
    logic        frame_end;
    logic        last;
  } chain_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  command_i;
  logic [2:0]  device_i;
  logic [3:0]  register_address_i;
  logic [7:0]  value_i;
  logic [2:0]  row_i;
  logic [2:0]  column_i;
  logic        flag_i;
  logic        word_valid_o;
  logic [15:0] word_o;
  logic [2:0]  word_device_o;
  logic        frame_end_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // expected frame words, oldest first
  chain_word_t frame_words_q[$];
  // mirror of the per-chip row bytes and of the chain length register
  logic [7:0]  row_mirror [64];
  logic [3:0]  chain_count_cfg;
  int          mismatch_count;
  int          idle_pct;
  int          watchdog_cnt;

  led_matrix_chain_controller_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .device_i           (device_i),
    .register_address_i (register_address_i),
    .value_i            (value_i),
    .row_i              (row_i),
    .column_i           (column_i),
    .flag_i             (flag_i),
    .word_valid_o       (word_valid_o),
    .word_o             (word_o),
    .word_device_o      (word_device_o),
    .frame_end_o        (frame_end_o),
    .last_o             (last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // effective chain length, saturated at the chain maximum
  function automatic int chain_len();
    return (chain_count_cfg > lmcc_pkg::MAX_DEVICES_DEF) ? lmcc_pkg::MAX_DEVICES_DEF
                                                         : int'(chain_count_cfg);
  endfunction

  // one frame: farthest chip first, target gets opcode and data, others a no-op
  function automatic void push_frame(input int n, input logic [2:0] target,
                                     input logic [7:0] opcode, input logic [7:0] data);
    chain_word_t w;
    for (int p = n - 1; p >= 0; p--) begin
      w.word      = (p == int'(target)) ? {opcode, data} : 16'h0000;
      w.device    = 3'(p);
      w.frame_end = (p == 0);
      w.last      = 1'b0;
      frame_words_q.push_back(w);
    end
  endfunction

  // expected words of one accepted command, shadow rows updated on the way
  function automatic void predict_chain_words(input host_cmd_t c);
    int         n;
    int         first;
    logic [5:0] idx;
    n     = chain_len();
    first = frame_words_q.size();
    idx   = {c.device, c.row};
    if (int'(c.device) >= n) return;
    case (c.command)
      lmcc_pkg::CMD_RAW: push_frame(n, c.device, {4'h0, c.reg_addr}, c.value);
      lmcc_pkg::CMD_SET_LED: begin
        if (c.flag) row_mirror[idx] = row_mirror[idx] | (lmcc_pkg::LED_MASK >> c.column);
        else row_mirror[idx] = row_mirror[idx] & ~(lmcc_pkg::LED_MASK >> c.column);
        push_frame(n, c.device, 8'(c.row) + 8'd1, row_mirror[idx]);
      end
      lmcc_pkg::CMD_CLEAR: begin
        for (int r = 0; r < 8; r++) begin
          row_mirror[{c.device, 3'(r)}] = 8'h00;
          push_frame(n, c.device, 8'(r + 1), 8'h00);
        end
      end
      lmcc_pkg::CMD_SCAN: begin
        if (c.value <= lmcc_pkg::SCAN_MAX)
          push_frame(n, c.device, lmcc_pkg::OPC_SCANLIMIT, c.value);
      end
      lmcc_pkg::CMD_INTENS: begin
        if (c.value <= lmcc_pkg::INTENS_MAX)
          push_frame(n, c.device, lmcc_pkg::OPC_INTENSITY, c.value);
      end
      lmcc_pkg::CMD_SHUTDOWN: begin
        push_frame(n, c.device, lmcc_pkg::OPC_SHUTDOWN, c.flag ? 8'h00 : 8'h01);
      end
      default: ;
    endcase
    if (frame_words_q.size() > first) frame_words_q[$].last = 1'b1;
  endfunction

  function automatic host_cmd_t build_cmd(input logic [2:0] cmd, input logic [2:0] dev,
                                          input logic [3:0] reg_addr, input logic [7:0] val,
                                          input logic [2:0] row, input logic [2:0] col,
                                          input logic flag);
    host_cmd_t c;
    c = '{command: cmd, device: dev, reg_addr: reg_addr, value: val,
          row: row, column: col, flag: flag};
    return c;
  endfunction

  // random command, mostly addressed inside the chain and in range
  function automatic host_cmd_t random_cmd();
    host_cmd_t c;
    int        n;
    n = chain_len();
    c = host_cmd_t'($urandom);
    if ($urandom_range(19) == 0) c.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else c.command = 3'($urandom_range(lmcc_pkg::CMD_RAW, lmcc_pkg::CMD_SHUTDOWN));
    // clears are long, keep them rarer
    if (c.command == lmcc_pkg::CMD_CLEAR && $urandom_range(1) == 0)
      c.command = lmcc_pkg::CMD_SET_LED;
    if (n > 0 && $urandom_range(9) != 0) c.device = 3'($urandom_range(n - 1));
    if (c.command == lmcc_pkg::CMD_SCAN && $urandom_range(4) != 0)
      c.value = 8'($urandom_range(lmcc_pkg::SCAN_MAX));
    if (c.command == lmcc_pkg::CMD_INTENS && $urandom_range(4) != 0)
      c.value = 8'($urandom_range(lmcc_pkg::INTENS_MAX));
    return c;
  endfunction

  // one command transaction, with random sender gaps before it
  task automatic send_host_cmd(input host_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start              <= 1'b1;
    command_i          <= c.command;
    device_i           <= c.device;
    register_address_i <= c.reg_addr;
    value_i            <= c.value;
    row_i              <= c.row;
    column_i           <= c.column;
    flag_i             <= c.flag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_chain_words(c);
  endtask

  // drop start, let every expected word arrive and the sequencer go idle
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    while (frame_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic read_check_chain_count(input logic [3:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= lmcc_pkg::ADDR_DEVICE_COUNT;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(want)) begin
      $display("%0t: device_count read: expected %h actual %h", $time, 32'(want), prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write transaction followed by a read back
  task automatic write_chain_count(input logic [3:0] cnt);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lmcc_pkg::ADDR_DEVICE_COUNT;
    pwdata  <= {28'($urandom), cnt};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    chain_count_cfg = cnt;
    read_check_chain_count(cnt);
  endtask

  task automatic test_reset_state();
    read_check_chain_count(lmcc_pkg::COUNT_RESET);
  endtask

  // field extremes, every command and the rejected cases at the reset length
  task automatic test_directed_commands();
    idle_pct = 0;
    send_host_cmd(build_cmd(lmcc_pkg::CMD_RAW, 3'd0, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_RAW, 3'd3, 4'hf, 8'hff, 3'd7, 3'd7, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd0, 4'h0, 8'h00, 3'd0, 3'd0, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd0, 4'h0, 8'h00, 3'd0, 3'd7, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd0, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd3, 4'h0, 8'h00, 3'd7, 3'd7, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_CLEAR, 3'd3, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd3, 4'h0, 8'h00, 3'd7, 3'd3, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SCAN, 3'd1, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SCAN, 3'd2, 4'h0, 8'h07, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SCAN, 3'd2, 4'h0, 8'h08, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_INTENS, 3'd0, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_INTENS, 3'd1, 4'h0, 8'h0f, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_INTENS, 3'd1, 4'h0, 8'h10, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_INTENS, 3'd1, 4'h0, 8'hff, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SHUTDOWN, 3'd2, 4'h0, 8'h00, 3'd0, 3'd0, 1'b1));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SHUTDOWN, 3'd2, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    // device past the end of the chain
    send_host_cmd(build_cmd(lmcc_pkg::CMD_RAW, 3'd4, 4'h5, 8'h5a, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(lmcc_pkg::CMD_SET_LED, 3'd7, 4'h0, 8'h00, 3'd2, 3'd2, 1'b1));
    // unknown commands
    send_host_cmd(build_cmd(CMD_UNUSED_LO, 3'd0, 4'h1, 8'h01, 3'd0, 3'd0, 1'b0));
    send_host_cmd(build_cmd(CMD_UNUSED_HI, 3'd0, 4'h1, 8'h01, 3'd0, 3'd0, 1'b1));
  endtask

  // shortest, longest, saturated and empty chains
  task automatic test_chain_length_extremes();
    logic [3:0] counts [5];
    counts = '{4'd1, 4'd8, 4'd15, 4'd9, 4'd0};
    foreach (counts[i]) begin
      wait_idle();
      write_chain_count(counts[i]);
      send_host_cmd(build_cmd(lmcc_pkg::CMD_RAW, 3'd7, 4'($urandom), 8'($urandom),
                              3'd0, 3'd0, 1'b0));
      send_host_cmd(build_cmd(lmcc_pkg::CMD_CLEAR, 3'd0, 4'h0, 8'h00, 3'd0, 3'd0, 1'b0));
    end
  endtask

  // random traffic, sender gaps rare, then frequent, then none, chain length per block
  task automatic test_random_traffic();
    int pcts [3];
    pcts = '{10, 74, 0};
    foreach (pcts[p]) begin
      for (int b = 0; b < 3; b++) begin
        wait_idle();
        if ($urandom_range(99) < 80) write_chain_count(4'($urandom_range(1, 8)));
        else write_chain_count(4'($urandom));
        idle_pct = pcts[p];
        repeat (BLOCK_ITEMS) send_host_cmd(random_cmd());
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each strobed word with the oldest expectation
  always @(posedge clk_i) begin : check_words
    chain_word_t want;
    if (rst_ni && word_valid_o) begin
      if (frame_words_q.size() == 0) begin
        $display("%0t: word: expected none actual %h device %0d frame_end %b last %b",
                 $time, word_o, word_device_o, frame_end_o, last_o);
        mismatch_count++;
      end else begin
        want = frame_words_q.pop_front();
        check_field("word", want.word, word_o);
        check_field("word_device", 16'(want.device), 16'(word_device_o));
        check_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || word_valid_o || (psel && penable && pready)) begin
      watchdog_cnt <= 0;
    end else if (watchdog_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      watchdog_cnt <= watchdog_cnt + 1;
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst_ni             = 1'b0;
    start              = 1'b0;
    command_i          = '0;
    device_i           = '0;
    register_address_i = '0;
    value_i            = '0;
    row_i              = '0;
    column_i           = '0;
    flag_i             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    mismatch_count     = 0;
    idle_pct           = 0;
    watchdog_cnt       = 0;
    chain_count_cfg    = lmcc_pkg::COUNT_RESET;
    foreach (row_mirror[i]) row_mirror[i] = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed_commands();
    test_chain_length_extremes();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0 && frame_words_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
